// File: rtl/assert_macros.svh
// Assertion macros used by the top level of the modular exponentiation block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is asserted
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// condition that must never be true
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `ASSERT_AT(lbl, clk, rstn, !(cond), msg)

`endif

// File: rtl/mexp_pkg.sv
// Package of the modular exponentiation block: defaults, register indexes,
// sequencer states and the multiplier status struct. No dependencies.
`default_nettype none

package mexp_pkg;

    localparam int WORD_BITS_DEFAULT = 64;
    localparam int CFG_INDEX_BITS    = 8;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_EXPONENT = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MODULUS  = 8'd1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_START = 4'b0010,
        ST_MUL   = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage

`default_nettype wire

// File: rtl/mexp_mod_add.sv
// Modular adder: a + b mod m for a, b below m, without overflow.
// No dependencies.
`default_nettype none

module mexp_mod_add #(
    parameter int WORD_BITS = 64
) (
    input  wire logic [WORD_BITS-1:0] a,
    input  wire logic [WORD_BITS-1:0] b,
    input  wire logic [WORD_BITS-1:0] m,
    output logic      [WORD_BITS-1:0] sum
);

    logic [WORD_BITS-1:0] gap;

    assign gap = m - b;
    assign sum = (a >= gap) ? (a - gap) : (a + b);

endmodule

`default_nettype wire

// File: rtl/mexp_mul_unit.sv
// Bit-serial modular multiplier: computes a*b0 mod m and a*b1 mod m together,
// one multiplier bit per cycle. Depends on mexp_pkg and mexp_mod_add.
`default_nettype none

module mexp_mul_unit
    import mexp_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [WORD_BITS-1:0] modulus,
    input  wire logic [WORD_BITS-1:0] a_in,
    input  wire logic [WORD_BITS-1:0] b0_in,
    input  wire logic [WORD_BITS-1:0] b1_in,
    output mul_stat_t                 stat,
    output logic      [WORD_BITS-1:0] p0,
    output logic      [WORD_BITS-1:0] p1
);

    localparam int CNT_BITS = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] a_reg, b0_reg, b1_reg, p0_reg, p1_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic                 busy_reg, done_reg;
    logic [WORD_BITS-1:0] a_dbl, p0_add, p1_add;

    mexp_mod_add #(.WORD_BITS(WORD_BITS)) u_add_dbl (
        .a(a_reg), .b(a_reg), .m(modulus), .sum(a_dbl)
    );
    mexp_mod_add #(.WORD_BITS(WORD_BITS)) u_add_p0 (
        .a(p0_reg), .b(a_reg), .m(modulus), .sum(p0_add)
    );
    mexp_mod_add #(.WORD_BITS(WORD_BITS)) u_add_p1 (
        .a(p1_reg), .b(a_reg), .m(modulus), .sum(p1_add)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(WORD_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= a_in;
            b0_reg <= b0_in;
            b1_reg <= b1_in;
            p0_reg <= '0;
            p1_reg <= '0;
        end else if (busy_reg) begin
            a_reg  <= a_dbl;
            b0_reg <= b0_reg >> 1;
            b1_reg <= b1_reg >> 1;
            if (b0_reg[0]) begin
                p0_reg <= p0_add;
            end
            if (b1_reg[0]) begin
                p1_reg <= p1_add;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign p0        = p0_reg;
    assign p1        = p1_reg;

endmodule

`default_nettype wire

// File: rtl/modular_exponentiation_64_unit.sv
// Top level of the modular exponentiation block: config registers, exponent
// sequencer and output register. Depends on mexp_pkg, mexp_mul_unit, assert_macros.svh.
//
// Each message transfer returns message^exponent mod modulus, scanning the
// exponent right to left over WORD_BITS bit positions. Every exponent bit runs
// one pass of the bit-serial multiplier, which forms the accumulator product and
// the base square side by side; each pass goes through the start and multiply
// states. A message not below the modulus, or a zero exponent, goes straight to
// the done state. s_axis_tready is high only between items; a finished result
// waits in the output register while the next message is taken.
`default_nettype none
`include "assert_macros.svh"

module modular_exponentiation_64_unit
    import mexp_pkg::*;
#(
    parameter  int WORD_BITS  = WORD_BITS_DEFAULT,
    localparam int TDATA_BITS = ((WORD_BITS + 7) / 8) * 8
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [WORD_BITS-1:0]      cfg_data,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [TDATA_BITS-1:0]     s_axis_tdata,  // message
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic      [TDATA_BITS-1:0]     m_axis_tdata,  // result
    output logic      [0:0]                m_axis_tuser   // range_error
);

    localparam int CNT_BITS = $clog2(WORD_BITS);

    state_t               state_reg, state_next;
    logic [WORD_BITS-1:0] exp_cfg_reg, mod_cfg_reg;
    logic [WORD_BITS-1:0] exp_reg, exp_next;
    logic [WORD_BITS-1:0] mod_reg, mod_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] base_reg, base_next;
    logic [WORD_BITS-1:0] res_reg, res_next;
    logic                 err_reg, err_next;
    logic [CNT_BITS-1:0]  bit_cnt_reg, bit_cnt_next;
    logic                 m_valid_reg, m_valid_next;
    logic [WORD_BITS-1:0] msg;
    logic [WORD_BITS-1:0] acc_upd;
    logic                 mul_start;
    mul_stat_t            mul_stat;
    logic [WORD_BITS-1:0] mul_p0, mul_p1;

    assign msg           = s_axis_tdata[WORD_BITS-1:0];
    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign mul_start     = (state_reg == ST_START);
    assign acc_upd       = exp_reg[0] ? mul_p0 : acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_cfg_reg <= '0;
            mod_cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_EXPONENT) begin
                exp_cfg_reg <= cfg_data;
            end
            if (cfg_index == CFG_MODULUS) begin
                mod_cfg_reg <= cfg_data;
            end
        end
    end

    mexp_mul_unit #(.WORD_BITS(WORD_BITS)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .modulus (mod_reg),
        .a_in    (base_reg),
        .b0_in   (acc_reg),
        .b1_in   (base_reg),
        .stat    (mul_stat),
        .p0      (mul_p0),
        .p1      (mul_p1)
    );

    always_comb begin
        state_next   = state_reg;
        exp_next     = exp_reg;
        mod_next     = mod_reg;
        acc_next     = acc_reg;
        base_next    = base_reg;
        res_next     = res_reg;
        err_next     = err_reg;
        bit_cnt_next = bit_cnt_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    exp_next     = exp_cfg_reg;
                    mod_next     = mod_cfg_reg;
                    base_next    = msg;
                    bit_cnt_next = '0;
                    acc_next     = (mod_cfg_reg == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
                    priority if (msg >= mod_cfg_reg) begin
                        res_next   = msg;
                        err_next   = 1'b1;
                        state_next = ST_DONE;
                    end else if (exp_cfg_reg == '0) begin
                        res_next   = WORD_BITS'(1);
                        err_next   = (mod_cfg_reg == WORD_BITS'(1));
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (mul_stat.done) begin
                    acc_next     = acc_upd;
                    base_next    = mul_p1;
                    exp_next     = exp_reg >> 1;
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                    if (bit_cnt_reg == CNT_BITS'(WORD_BITS - 1)) begin
                        res_next   = acc_upd;
                        err_next   = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_START;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            bit_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        exp_reg  <= exp_next;
        mod_reg  <= mod_next;
        acc_reg  <= acc_next;
        base_reg <= base_next;
        res_reg  <= res_next;
        err_reg  <= err_next;
    end

    logic [WORD_BITS-1:0] out_res;
    logic                 out_err;

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DONE) && (!m_valid_reg || m_axis_tready)) begin
            out_res <= res_reg;
            out_err <= err_reg;
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = TDATA_BITS'(out_res);
    assign m_axis_tuser[0] = out_err;

    `ASSERT_NEVER(a_start_idle_unit, aclk, aresetn, mul_start && mul_stat.busy,
        "multiplier started while busy")
    `ASSERT_AT(a_done_in_mul, aclk, aresetn, mul_stat.done |-> (state_reg == ST_MUL),
        "multiplier finished outside the multiply state")
    `ASSERT_AT(a_result_reduced, aclk, aresetn,
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (out_res < mod_cfg_reg),
        "error-free result not below modulus")

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for modular_exponentiation_64_unit: directed and random
// messages under several exponent/modulus keys, checked against an in-bench predictor.
// Depends on mexp_pkg and the RTL of the block.
`default_nettype none

module tb_top;
    import mexp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD        = 64;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RAND_KEYS   = 6;
    localparam int RAND_PER_KEY = 20;

    typedef struct packed {
        logic [WORD-1:0] result;
        logic            range_error;
    } residue_t;

    typedef struct packed {
        logic [CFG_INDEX_BITS-1:0] index;
        logic [WORD-1:0]           data;
    } key_write_t;

    logic                      aclk;
    logic                      aresetn       = 1'b0;
    logic                      cfg_valid     = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index     = CFG_EXPONENT;
    logic [WORD-1:0]           cfg_data      = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [WORD-1:0]           s_axis_tdata  = '0;  // message
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [WORD-1:0]           m_axis_tdata;        // result
    logic [0:0]                m_axis_tuser;        // range_error

    modular_exponentiation_64_unit #(.WORD_BITS(WORD)) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    key_write_t      key_q[$];
    logic [WORD-1:0] message_q[$];
    residue_t        residue_q[$];

    logic [WORD-1:0] key_exponent = '0;
    logic [WORD-1:0] key_modulus  = '0;
    bit              quiet        = 1'b0;
    int              feed_gap     = 0;
    int              drain_hold   = 0;
    int              n_sent       = 0;
    int              n_flagged    = 0;
    int              n_keys       = 0;
    int              n_fail       = 0;
    int              n_cycles     = 0;
    key_write_t      wr;
    residue_t        want;

    // a + b mod n without overflow, a and b below n
    function automatic logic [WORD-1:0] mod_sum(input logic [WORD-1:0] a, b, n);
        logic [WORD-1:0] gap;
        gap = n - b;
        return (a >= gap) ? a - gap : a + b;
    endfunction

    // a * b mod n, shift-and-add over the bits of b
    function automatic logic [WORD-1:0] mod_product(input logic [WORD-1:0] a, b, n);
        logic [WORD-1:0] acc;
        logic [WORD-1:0] x;
        acc = '0;
        x   = a;
        for (int i = 0; i < WORD; i++) begin
            if (b[i])
                acc = mod_sum(acc, x, n);
            x = mod_sum(x, x, n);
        end
        return acc;
    endfunction

    function automatic residue_t predict_residue(input logic [WORD-1:0] msg, e, n);
        residue_t        r;
        logic [WORD-1:0] acc;
        logic [WORD-1:0] base;
        if (msg >= n) begin
            r.result      = msg;
            r.range_error = 1'b1;
            return r;
        end
        if (e == '0) begin
            acc = 64'd1;
        end else begin
            acc  = (n == 64'd1) ? 64'd0 : 64'd1;
            base = msg;
            for (int i = 0; i < WORD; i++) begin
                if (e[i])
                    acc = mod_product(base, acc, n);
                base = mod_product(base, base, n);
            end
        end
        r.result      = acc;
        r.range_error = (acc >= n);
        return r;
    endfunction

    function automatic logic [WORD-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // driver: config channel and message channel
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_valid     <= 1'b0;
            s_axis_tvalid <= 1'b0;
            feed_gap      = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_EXPONENT)
                    key_exponent = cfg_data;
                else if (cfg_index == CFG_MODULUS)
                    key_modulus = cfg_data;
            end
            if (!cfg_valid || cfg_ready) begin
                if (key_q.size() > 0) begin
                    wr = key_q.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= wr.index;
                    cfg_data  <= wr.data;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                residue_q.push_back(predict_residue(s_axis_tdata, key_exponent, key_modulus));
                n_sent++;
                if (!quiet && $urandom_range(0, 2) == 0)
                    feed_gap = $urandom_range(1, 8);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                // gap counts down only while the block can take a transfer
                if (feed_gap > 0) begin
                    if (s_axis_tready)
                        feed_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (message_q.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= message_q.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: result channel
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            drain_hold    = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (m_axis_tuser[0])
                    n_flagged++;
                if (residue_q.size() == 0) begin
                    $display("%0t: unexpected result %h range_error %b", $time,
                             m_axis_tdata, m_axis_tuser[0]);
                    n_fail++;
                end else begin
                    want = residue_q.pop_front();
                    if (m_axis_tdata !== want.result) begin
                        $display("%0t: result mismatch, expected %h actual %h", $time,
                                 want.result, m_axis_tdata);
                        n_fail++;
                    end
                    if (m_axis_tuser[0] !== want.range_error) begin
                        $display("%0t: range_error mismatch, expected %b actual %b", $time,
                                 want.range_error, m_axis_tuser[0]);
                        n_fail++;
                    end
                end
            end
            if (drain_hold > 0) begin
                drain_hold--;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                drain_hold = $urandom_range(0, 7);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", n_cycles,
                     residue_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // wait until both channels are empty and every result is back
    task automatic settle();
        do @(negedge aclk);
        while (key_q.size() != 0 || cfg_valid || message_q.size() != 0 || s_axis_tvalid
               || residue_q.size() != 0);
    endtask

    task automatic program_key(input logic [WORD-1:0] e, n);
        settle();
        key_q.push_back('{CFG_EXPONENT, e});
        key_q.push_back('{CFG_MODULUS, n});
        n_keys++;
        settle();
    endtask

    task automatic send(input logic [WORD-1:0] msg);
        message_q.push_back(msg);
    endtask

    initial begin
        logic [WORD-1:0] e;
        logic [WORD-1:0] n;
        logic [WORD-1:0] msg;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // modulus still zero after reset: everything out of range
        send('0);
        send('1);

        // zero exponent, modulus 1
        program_key('0, 64'd1);
        send('0);
        send(64'd1);

        program_key('0, '1);
        send(64'd5);
        send(64'h8000_0000_0000_0000);

        program_key('1, '1);
        send('0);
        send(64'd1);
        send(64'd2);
        send(64'hffff_ffff_ffff_fffe);
        send('1);

        program_key(64'd2, 64'd1);
        send('0);

        program_key(64'd1, 64'h8000_0000_0000_001d);
        send(rand_word() >> 1);
        send(64'h8000_0000_0000_001c);

        program_key(64'd65537, 64'hc7f1_4ae3_9b05_d2b7);
        send(64'h5555_5555_5555_5555);
        send(64'h2aaa_aaaa_aaaa_aaaa);
        send(rand_word() % 64'hc7f1_4ae3_9b05_d2b7);
        send(64'hc7f1_4ae3_9b05_d2b7);

        program_key(64'd3, 64'd2);
        send(64'd1);
        send('0);

        for (int k = 0; k < RAND_KEYS; k++) begin
            settle();
            if (k == RAND_KEYS - 1)
                quiet = 1'b1;
            case ($urandom_range(0, 3))
                0:       n = rand_word() | 64'h8000_0000_0000_0000;
                1:       n = rand_word() >> $urandom_range(1, 60);
                2:       n = 64'($urandom_range(2, 300));
                default: n = rand_word();
            endcase
            e = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 70000)) : rand_word();
            program_key(e, n);
            repeat (RAND_PER_KEY) begin
                msg = rand_word();
                if (n != 0 && $urandom_range(0, 6) != 0)
                    msg = msg % n;
                send(msg);
            end
        end

        settle();
        repeat (50) @(negedge aclk);
        $display("%0d messages over %0d keys, %0d flagged out of range, %0d mismatches",
                 n_sent, n_keys, n_flagged, n_fail);
        if (n_fail == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: modular_exponentiation_64_unit.f
+incdir+rtl
rtl/mexp_pkg.sv
rtl/mexp_mod_add.sv
rtl/mexp_mul_unit.sv
rtl/modular_exponentiation_64_unit.sv
verif/tb_top.sv
